// ===== hw/rtl/pidpc_pkg.sv =====
// Shared types, register codes and arithmetic constants of the PID position controller.
`timescale 1ns / 1ps

package pidpc_pkg;

  localparam int REG_W     = 32;
  localparam int REG_IDX_W = 3;
  localparam int CNT_W     = 6;

  typedef logic        [31:0] ms_t;
  typedef logic signed [31:0] pos_t;
  typedef logic signed [15:0] drive_t;
  typedef logic signed [40:0] vel_t;

  localparam logic [REG_IDX_W-1:0] REG_SET_POINT  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_P     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_I     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_D     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_START_TIME = 3'd4;

  // velocity sampling interval in microseconds, 1 .. 1000000
  localparam int          VELOCITY_INTERVAL_US = 22700;
  localparam logic [31:0] VEL_SCALE            = 32'd1000000;

  // scale / interval as a rounded-up reciprocal over 2^VEL_SHIFT; exact for any
  // position delta below 2^32 in magnitude
  localparam int          VEL_POST_SHIFT = $clog2(VELOCITY_INTERVAL_US);
  localparam int          VEL_SHIFT      = 32 + VEL_POST_SHIFT;
  localparam logic [95:0] VEL_RECIP_WIDE = ((96'(VEL_SCALE) << VEL_SHIFT) +
                                            96'(VELOCITY_INTERVAL_US) - 96'd1) /
                                           96'(VELOCITY_INTERVAL_US);
  localparam logic [63:0] VEL_RECIP      = VEL_RECIP_WIDE[63:0];

  // a 33-bit position delta times the scale stays below 2^52 for any interval
  localparam int                 VEL_Q_W     = 52;
  localparam logic [VEL_Q_W-1:0] VEL_NEG_MAG = {{(VEL_Q_W-41){1'b0}}, 1'b1, 40'd0};
  localparam logic [40:0]        VEL_MAX     = {1'b0, {40{1'b1}}};
  localparam logic [40:0]        VEL_MIN     = {1'b1, 40'd0};

  localparam logic [61:0] TERM_LIMIT  = {1'b1, 61'd0};
  localparam logic [65:0] ONE_Q16     = 66'd65536;
  localparam logic [65:0] NEG_ONE_Q16 = ~ONE_Q16 + 66'd1;
  localparam logic [63:0] INT64_MAX   = {1'b0, {63{1'b1}}};
  localparam logic [63:0] INT64_MIN   = {1'b1, 63'd0};

  localparam drive_t DRIVE_ONE     = 16'sd16384;
  localparam drive_t DRIVE_NEG_ONE = -16'sd16384;

  localparam logic [CNT_W-1:0] MUL_LAST = 6'd31;
  localparam logic [CNT_W-1:0] DIV_LAST = 6'd63;

endpackage

// ===== hw/rtl/pidpc_sample_if.sv =====
// Input channel: timestamp and encoder position with valid/ready.
`timescale 1ns / 1ps

interface pidpc_sample_if;
  logic            valid;
  logic            ready;
  pidpc_pkg::ms_t  now_ms;
  pidpc_pkg::pos_t position;

  modport source (output valid, output now_ms, output position, input ready);
  modport sink   (input valid, input now_ms, input position, output ready);
endinterface

// ===== hw/rtl/pidpc_result_if.sv =====
// Output channel: clamped drive, clamp flag and velocity with valid/ready.
`timescale 1ns / 1ps

interface pidpc_result_if;
  logic              valid;
  logic              ready;
  pidpc_pkg::drive_t drive;
  logic              clamped;
  pidpc_pkg::vel_t   velocity;

  modport source (output valid, output drive, output clamped, output velocity, input ready);
  modport sink   (input valid, input drive, input clamped, input velocity, output ready);
endinterface

// ===== hw/rtl/pid_position_controller.sv =====
// PID position loop with clamped Q2.14 drive and velocity estimate, built on one shared adder.
`timescale 1ns / 1ps

// Usage
//   sample : now_ms (ms timestamp) and position (encoder counts), valid/ready.
//   result : drive (Q2.14, -1.0..+1.0), clamped flag and velocity, valid/ready.
//   wr_en/wr_index/wr_data : register writes (set point, three Q16.16 gains,
//   start time); write only while no item is in flight.
// Operation
//   One item at a time. sample.ready rises together with the result valid,
//   so a new item is taken only once the last result is registered. The
//   work runs on the single 66-bit adder: five 32-step shift-add multiplies
//   (the velocity one by a fixed reciprocal) and up to one 64-step restoring
//   division run on it in turn; the division is skipped when now_ms equals
//   the previous timestamp.
// Reset clears the registers and the loop state (previous time, error,
// position and the integral) and empties the output register.
// A result waits in the output register while the receiver stalls; the
// next item is still accepted and runs to completion, then holds until the
// output register is free.
module pid_position_controller (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [pidpc_pkg::REG_IDX_W-1:0]   wr_index,
  input  logic [pidpc_pkg::REG_W-1:0]       wr_data,
  pidpc_sample_if.sink                      sample,
  pidpc_result_if.source                    result
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PREP = 4'd1;
  localparam logic [3:0] S_VMUL = 4'd2;
  localparam logic [3:0] S_IMUL = 4'd4;
  localparam logic [3:0] S_IADD = 4'd5;
  localparam logic [3:0] S_PMUL = 4'd6;
  localparam logic [3:0] S_SABS = 4'd7;
  localparam logic [3:0] S_GMUL = 4'd8;
  localparam logic [3:0] S_DMUL = 4'd9;
  localparam logic [3:0] S_DDIV = 4'd10;
  localparam logic [3:0] S_RAWP = 4'd11;
  localparam logic [3:0] S_RAWI = 4'd12;
  localparam logic [3:0] S_RAWD = 4'd13;
  localparam logic [3:0] S_DONE = 4'd14;

  logic [3:0]                  state;
  logic [pidpc_pkg::CNT_W-1:0] cnt;

  logic signed [31:0] set_point, gain_p, gain_i, gain_d;
  logic        [31:0] prev_time;
  logic signed [63:0] error_sum;
  logic signed [32:0] prev_error;
  logic signed [31:0] prev_position;

  logic        [31:0] now_r;
  logic signed [31:0] pos_r;
  logic        [31:0] dt;
  logic signed [32:0] err, dpos;
  logic        [31:0] mag_err;
  logic        [32:0] mag_diff;
  logic               neg_vel, neg_p, neg_i, neg_d;

  logic [65:0] acc;
  logic [63:0] mcand;
  logic [31:0] mplier;
  logic        sat;
  logic [31:0] rem;
  logic [63:0] quo;

  logic [pidpc_pkg::VEL_Q_W-1:0] vel_q;
  logic [61:0]                   tp, ti, td;

  // shared unit and helpers
  logic [65:0] add_a, add_b, add_y;
  logic        add_sub;
  logic        is_mul, is_div, sat_en, sat_next;
  logic [65:0] mul_next, racc_next, vel_shift;
  logic [61:0] mul_term, div_term;
  logic [31:0] rem_next;
  logic        div_bit;
  logic [63:0] quo_next;
  logic [33:0] diff_fw, diff_bw;
  logic [32:0] err_neg, dpos_neg;
  logic [31:0] err_abs, dpos_abs, mag_gp, mag_gi, mag_gd;
  logic [63:0] isum_clip;
  logic        clip_hi, clip_lo, out_free;
  logic [15:0] drive_q;
  logic [40:0] vel_out;

  assign sample.ready = (state == S_IDLE);
  assign out_free     = !result.valid || result.ready;

  assign is_mul = (state == S_IMUL) || (state == S_PMUL) ||
                  (state == S_GMUL) || (state == S_DMUL);
  assign is_div = (state == S_DDIV);
  assign sat_en = (state == S_PMUL) || (state == S_GMUL);

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state) inside
      S_IMUL, S_PMUL, S_GMUL, S_DMUL: begin
        add_a = {acc[64:0], 1'b0};
        add_b = mplier[31] ? {2'b00, mcand} : 66'd0;
      end
      S_VMUL: begin
        add_a = acc;
        add_b = mplier[0] ? {2'b00, mcand} : 66'd0;
      end
      S_DDIV: begin
        add_a   = {33'd0, rem, quo[63]};
        add_b   = {34'd0, dt};
        add_sub = 1'b1;
      end
      S_IADD: begin
        add_a   = {{2{error_sum[63]}}, error_sum};
        add_b   = acc;
        add_sub = err[32];
      end
      S_SABS: begin
        add_b   = {{2{error_sum[63]}}, error_sum};
        add_sub = error_sum[63];
      end
      S_RAWP: begin
        add_b   = {4'd0, tp};
        add_sub = neg_p;
      end
      S_RAWI: begin
        add_a   = acc;
        add_b   = {4'd0, ti};
        add_sub = neg_i;
      end
      S_RAWD: begin
        add_a   = acc;
        add_b   = {4'd0, td};
        add_sub = neg_d;
      end
      default: ;
    endcase
    add_y = add_a + (add_sub ? ~add_b : add_b) + {65'd0, add_sub};
  end

  // once a capped product passes the limit it can only grow: freeze it
  assign sat_next = sat || (sat_en && (add_y > {4'd0, pidpc_pkg::TERM_LIMIT}));
  assign mul_next = (sat_en && sat) ? acc : add_y;
  assign mul_term = sat_next ? pidpc_pkg::TERM_LIMIT : mul_next[61:0];

  // LSB first: the low product bits drop off, leaving delta * recip / 2^32
  assign racc_next = {1'b0, add_y[65:1]};
  assign vel_shift = racc_next >> pidpc_pkg::VEL_POST_SHIFT;

  assign div_bit  = !add_y[65];
  assign rem_next = div_bit ? add_y[31:0] : {rem[30:0], quo[63]};
  assign quo_next = {quo[62:0], div_bit};
  assign div_term = (quo_next > {2'b00, pidpc_pkg::TERM_LIMIT}) ?
                    pidpc_pkg::TERM_LIMIT : quo_next[61:0];

  assign diff_fw  = {err[32], err} - {prev_error[32], prev_error};
  assign diff_bw  = {prev_error[32], prev_error} - {err[32], err};
  assign err_neg  = 33'd0 - err;
  assign dpos_neg = 33'd0 - dpos;
  assign err_abs  = err[32] ? err_neg[31:0] : err[31:0];
  assign dpos_abs = dpos[32] ? dpos_neg[31:0] : dpos[31:0];
  assign mag_gp   = gain_p[31] ? (32'd0 - gain_p) : gain_p;
  assign mag_gi   = gain_i[31] ? (32'd0 - gain_i) : gain_i;
  assign mag_gd   = gain_d[31] ? (32'd0 - gain_d) : gain_d;

  assign isum_clip = ((add_y[65:63] == 3'b000) || (add_y[65:63] == 3'b111)) ? add_y[63:0] :
                     (add_y[65] ? pidpc_pkg::INT64_MIN : pidpc_pkg::INT64_MAX);

  assign clip_hi = !acc[65] && (acc > pidpc_pkg::ONE_Q16);
  assign clip_lo = acc[65] && (acc < pidpc_pkg::NEG_ONE_Q16);
  // divide by four, rounding toward zero
  assign drive_q = acc[17:2] + {15'd0, acc[65] & (|acc[1:0])};

  always_comb begin
    if (neg_vel) begin
      vel_out = (vel_q > pidpc_pkg::VEL_NEG_MAG) ? pidpc_pkg::VEL_MIN : (41'd0 - vel_q[40:0]);
    end else begin
      vel_out = (|vel_q[pidpc_pkg::VEL_Q_W-1:40]) ? pidpc_pkg::VEL_MAX : {1'b0, vel_q[39:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      result.valid  <= 1'b0;
      set_point     <= '0;
      gain_p        <= '0;
      gain_i        <= '0;
      gain_d        <= '0;
      prev_time     <= '0;
      error_sum     <= '0;
      prev_error    <= '0;
      prev_position <= '0;
    end else begin
      if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end

      if (is_mul) begin
        acc    <= mul_next;
        sat    <= sat_next;
        mplier <= {mplier[30:0], 1'b0};
        cnt    <= cnt + 1'b1;
      end
      if (state == S_VMUL) begin
        acc    <= racc_next;
        mplier <= {1'b0, mplier[31:1]};
        cnt    <= cnt + 1'b1;
      end
      if (is_div) begin
        rem <= rem_next;
        quo <= quo_next;
        cnt <= cnt + 1'b1;
      end

      unique case (state)
        S_IDLE: if (sample.valid) begin
          now_r <= sample.now_ms;
          pos_r <= sample.position;
          dt    <= sample.now_ms - prev_time;
          err   <= {set_point[31], set_point} - {sample.position[31], sample.position};
          dpos  <= {sample.position[31], sample.position} -
                   {prev_position[31], prev_position};
          state <= S_PREP;
        end
        S_PREP: begin
          mag_err       <= err_abs;
          mag_diff      <= diff_fw[33] ? diff_bw[32:0] : diff_fw[32:0];
          neg_vel       <= dpos[32];
          neg_p         <= gain_p[31] ^ err[32];
          neg_d         <= gain_d[31] ^ diff_fw[33];
          prev_error    <= err;
          prev_position <= pos_r;
          prev_time     <= now_r;
          acc           <= '0;
          sat           <= 1'b0;
          cnt           <= '0;
          mcand         <= pidpc_pkg::VEL_RECIP;
          mplier        <= dpos_abs;
          state         <= S_VMUL;
        end
        S_VMUL: if (cnt == pidpc_pkg::MUL_LAST) begin
          vel_q  <= vel_shift[pidpc_pkg::VEL_Q_W-1:0];
          acc    <= '0;
          sat    <= 1'b0;
          cnt    <= '0;
          mcand  <= {32'd0, mag_err};
          mplier <= dt;
          state  <= S_IMUL;
        end
        S_IMUL: if (cnt == pidpc_pkg::MUL_LAST) begin
          state <= S_IADD;
        end
        S_IADD: begin
          error_sum <= isum_clip;
          acc       <= '0;
          sat       <= 1'b0;
          cnt       <= '0;
          mcand     <= {32'd0, mag_err};
          mplier    <= mag_gp;
          state     <= S_PMUL;
        end
        S_PMUL: if (cnt == pidpc_pkg::MUL_LAST) begin
          tp    <= mul_term;
          state <= S_SABS;
        end
        S_SABS: begin
          mcand  <= add_y[63:0];
          neg_i  <= gain_i[31] ^ error_sum[63];
          acc    <= '0;
          sat    <= 1'b0;
          cnt    <= '0;
          mplier <= mag_gi;
          state  <= S_GMUL;
        end
        S_GMUL: if (cnt == pidpc_pkg::MUL_LAST) begin
          ti     <= mul_term;
          acc    <= '0;
          sat    <= 1'b0;
          cnt    <= '0;
          mcand  <= {31'd0, mag_diff};
          mplier <= mag_gd;
          state  <= S_DMUL;
        end
        S_DMUL: if (cnt == pidpc_pkg::MUL_LAST) begin
          if (dt == 32'd0) begin
            td    <= '0;
            state <= S_RAWP;
          end else begin
            quo   <= mul_next[63:0];
            rem   <= '0;
            cnt   <= '0;
            state <= S_DDIV;
          end
        end
        S_DDIV: if (cnt == pidpc_pkg::DIV_LAST) begin
          td    <= div_term;
          state <= S_RAWP;
        end
        S_RAWP: begin
          acc   <= add_y;
          state <= S_RAWI;
        end
        S_RAWI: begin
          acc   <= add_y;
          state <= S_RAWD;
        end
        S_RAWD: begin
          acc   <= add_y;
          state <= S_DONE;
        end
        S_DONE: if (out_free) begin
          result.valid    <= 1'b1;
          result.drive    <= clip_hi ? pidpc_pkg::DRIVE_ONE :
                             (clip_lo ? pidpc_pkg::DRIVE_NEG_ONE : $signed(drive_q));
          result.clamped  <= clip_hi | clip_lo;
          result.velocity <= vel_out;
          state           <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase

      if (wr_en) begin
        unique case (wr_index)
          pidpc_pkg::REG_SET_POINT:  set_point <= wr_data;
          pidpc_pkg::REG_GAIN_P:     gain_p    <= wr_data;
          pidpc_pkg::REG_GAIN_I:     gain_i    <= wr_data;
          pidpc_pkg::REG_GAIN_D:     gain_d    <= wr_data;
          pidpc_pkg::REG_START_TIME: prev_time <= wr_data;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== hw/rtl/pidpc_checker.sv =====
// Port-level checks of the PID position controller, bound to the top level.
`timescale 1ns / 1ps

module pidpc_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input pidpc_pkg::drive_t drive,
  input logic              clamped
);

  // one item at a time: no second item straight after an accepted one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in flight");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (drive <= pidpc_pkg::DRIVE_ONE) && (drive >= pidpc_pkg::DRIVE_NEG_ONE))
    else $error("drive outside -1.0 .. +1.0");

  a_clamp_full_scale: assert property (@(posedge clk) disable iff (rst)
    out_valid && clamped |-> (drive == pidpc_pkg::DRIVE_ONE) ||
                             (drive == pidpc_pkg::DRIVE_NEG_ONE))
    else $error("clamp flag without full-scale drive");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(drive) && $stable(clamped))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind pid_position_controller pidpc_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample.valid),
  .in_ready  (sample.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .drive     (result.drive),
  .clamped   (result.clamped)
);
